>>> hw/rtl/tsnp_pkg.sv
// Shared types and constants for the tune string note parser.
// Used by tsnp_ctrl, tsnp_dp and tune_string_note_parser_unit; no dependencies.
package tsnp_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OCT_WAIT,
        MODE_LEN_NUM,
        MODE_TEMPO_NUM,
        MODE_NOTE_ACC,
        MODE_NOTE_NUM,
        MODE_PAUSE_NUM
    } mode_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_MUL,
        CS_DIV,
        CS_DUR,
        CS_X85,
        CS_SCALE,
        CS_LOAD
    } cstate_t;

    typedef struct packed {
        logic take;   // accept the input word and parse it
        logic mul;    // form tempo * length
        logic div;    // one restoring divide step
        logic dur;    // settle duration (or saturate)
        logic x85;    // duration * 85
        logic scale;  // * reciprocal of 100
        logic load;   // move result into the output register
    } cmd_t;

    typedef struct packed {
        logic ev;       // parsed word produces an event
        logic out_free; // output register can take a result
    } sts_t;

    localparam int DUR_W      = 19;
    localparam int FREQ_W     = 13;
    localparam int DIV_STEPS  = DUR_W;
    localparam int CNT_W      = 5;
    localparam logic [DUR_W-1:0] DUR_SAT   = 19'd360000;
    localparam logic [DUR_W-1:0] DUR_PLAIN = 19'd240000;
    localparam logic [DUR_W-1:0] DUR_DOT   = 19'd360000;
    localparam int X85_W      = 25;
    localparam logic [6:0] PCT85 = 7'd85;
    // ceil(2^32 / 100): exact floor(x / 100) for x below 2^30
    localparam int RECIP_W    = 26;
    localparam logic [RECIP_W-1:0] RECIP100 = 26'd42949673;
    localparam int RECIP_SH   = 32;
    localparam int SCALE_W    = X85_W + RECIP_W;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [2:0] OCT_RST = 3'd4;
    localparam logic [2:0] OCT_MIN = 3'd1;
    localparam logic [2:0] OCT_MAX = 3'd7;

    function automatic logic [FREQ_W-1:0] base_freq(input logic [4:0] slot);
        logic [FREQ_W-1:0] f;
        case (slot)
            5'd0:  f = 13'd440;
            5'd1:  f = 13'd415;
            5'd2:  f = 13'd466;
            5'd3:  f = 13'd494;
            5'd4:  f = 13'd466;
            5'd5:  f = 13'd523;
            5'd6:  f = 13'd262;
            5'd7:  f = 13'd247;
            5'd8:  f = 13'd277;
            5'd9:  f = 13'd294;
            5'd10: f = 13'd277;
            5'd11: f = 13'd311;
            5'd12: f = 13'd330;
            5'd13: f = 13'd311;
            5'd14: f = 13'd349;
            5'd15: f = 13'd349;
            5'd16: f = 13'd330;
            5'd17: f = 13'd370;
            5'd18: f = 13'd392;
            5'd19: f = 13'd370;
            5'd20: f = 13'd415;
            default: f = 13'd440;
        endcase
        return f;
    endfunction

endpackage

>>> hw/rtl/tsnp_ctrl.sv
// Sequencer for the tune string note parser: accept, multiply, divide, scale, load.
// Depends on tsnp_pkg.
module tsnp_ctrl
    import tsnp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  sts_t sts,
    output logic in_ready,
    output cmd_t cmd
);

    cstate_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid && sts.ev)
                    state_next = CS_MUL;
            end
            CS_MUL:
            begin
                cnt_next   = '0;
                state_next = CS_DIV;
            end
            CS_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = CS_DUR;
            end
            CS_DUR:   state_next = CS_X85;
            CS_X85:   state_next = CS_SCALE;
            CS_SCALE: state_next = CS_LOAD;
            CS_LOAD:
            begin
                if (sts.out_free)
                    state_next = CS_IDLE;
            end
            default:  state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            CS_MUL:   cmd.mul   = 1'b1;
            CS_DIV:   cmd.div   = 1'b1;
            CS_DUR:   cmd.dur   = 1'b1;
            CS_X85:   cmd.x85   = 1'b1;
            CS_SCALE: cmd.scale = 1'b1;
            CS_LOAD:  cmd.load  = sts.out_free;
            default:  cmd       = '0;
        endcase
    end

endmodule

>>> hw/rtl/tsnp_dp.sv
// Datapath for the tune string note parser: parser state, divider, scaler, output register.
// Depends on tsnp_pkg.
module tsnp_dp
    import tsnp_pkg::*;
#(
    parameter int NUMBER_MAX = 999
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  ch,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [55:0] out_data
);

    localparam int NW = $clog2(NUMBER_MAX + 1);
    localparam int PW = 2 * NW;
    localparam logic [NW-1:0] NMAX  = NW'(NUMBER_MAX);
    localparam logic [NW-1:0] T_RST = NW'(120);
    localparam logic [NW-1:0] L_RST = NW'(4);

    mode_t           mode_reg, mode_next;
    logic [2:0]      oct_reg, oct_next;
    logic [NW-1:0]   tempo_reg, tempo_next;
    logic [NW-1:0]   dlen_reg, dlen_next;
    logic [NW-1:0]   num_reg, num_next;
    logic [4:0]      slot_reg, slot_next;

    logic            ev, ev_pause, ev_dot, go, is_dig;
    logic [NW+3:0]   acc_wide;
    logic [NW-1:0]   acc;
    logic [NW-1:0]   ev_len;
    logic [FREQ_W-1:0] ev_freq, bf;

    // event job registers
    logic              job_pause_reg, job_dot_reg, job_sat_reg;
    logic [FREQ_W-1:0] job_freq_reg;
    logic [NW-1:0]     job_tempo_reg, job_len_reg;
    logic [PW-1:0]     prod_reg;
    logic [PW-1:0]     rem_reg;
    logic [DUR_W-1:0]  quo_reg;
    logic [PW:0]       rem_sh;
    logic [DUR_W-1:0]  dur_reg;
    logic [X85_W-1:0]  x85_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic              out_valid_reg;
    logic              o_pause_reg;
    logic [FREQ_W-1:0] o_freq_reg;
    logic [DUR_W-1:0]  o_dur_reg, o_snd_reg;

    assign is_dig   = (ch >= CH_0) && (ch <= CH_9);
    assign acc_wide = (NW+4)'(num_reg) * (NW+4)'(10) + (NW+4)'(ch - CH_0);
    assign acc      = (acc_wide > (NW+4)'(NMAX)) ? NMAX : acc_wide[NW-1:0];
    assign ev_len   = (num_reg != '0) ? num_reg : dlen_reg;
    assign bf       = base_freq((slot_reg < 5'd21) ? slot_reg : 5'd0);
    assign ev_freq  = (oct_reg < OCT_RST) ? (bf >> (OCT_RST - oct_reg))
                                          : (bf << (oct_reg - OCT_RST));

    always_comb
    begin
        mode_next  = mode_reg;
        oct_next   = oct_reg;
        tempo_next = tempo_reg;
        dlen_next  = dlen_reg;
        num_next   = num_reg;
        slot_next  = slot_reg;
        ev         = 1'b0;
        ev_pause   = 1'b0;
        ev_dot     = 1'b0;
        go         = 1'b1;
        case (mode_reg)
            MODE_OCT_WAIT:
            begin
                mode_next = MODE_IDLE;
                if (ch >= CH_1 && ch <= CH_7)
                begin
                    oct_next = ch[2:0];
                    go       = 1'b0;
                end
            end
            MODE_LEN_NUM, MODE_TEMPO_NUM:
            begin
                if (is_dig)
                begin
                    num_next = acc;
                    go       = 1'b0;
                end
                else
                begin
                    if (mode_reg == MODE_TEMPO_NUM)
                        tempo_next = num_reg;
                    else if (num_reg != '0)
                        dlen_next = num_reg;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NOTE_ACC, MODE_NOTE_NUM, MODE_PAUSE_NUM:
            begin
                if (mode_reg == MODE_NOTE_ACC && (ch == CH_MINUS || ch == CH_PLUS))
                begin
                    slot_next = slot_reg + ((ch == CH_MINUS) ? 5'd1 : 5'd2);
                    mode_next = MODE_NOTE_NUM;
                    go        = 1'b0;
                end
                else if (is_dig)
                begin
                    num_next  = acc;
                    mode_next = (mode_reg == MODE_NOTE_ACC) ? MODE_NOTE_NUM : mode_reg;
                    go        = 1'b0;
                end
                else
                begin
                    ev        = 1'b1;
                    ev_pause  = (mode_reg == MODE_PAUSE_NUM);
                    ev_dot    = (ch == CH_DOT);
                    mode_next = MODE_IDLE;
                    if (ev_dot)
                        go = 1'b0;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase

        if (go)
        begin
            if (ch == CH_NUL)
            begin
                mode_next  = MODE_IDLE;
                oct_next   = OCT_RST;
                tempo_next = T_RST;
                dlen_next  = L_RST;
                num_next   = '0;
                slot_next  = '0;
            end
            else if (ch == CH_LT)
            begin
                if (oct_reg > OCT_MIN)
                    oct_next = oct_reg - 3'd1;
            end
            else if (ch == CH_GT)
            begin
                if (oct_reg < OCT_MAX)
                    oct_next = oct_reg + 3'd1;
            end
            else if (ch == CH_O)
                mode_next = MODE_OCT_WAIT;
            else if (ch == CH_L)
            begin
                mode_next = MODE_LEN_NUM;
                num_next  = '0;
            end
            else if (ch == CH_T)
            begin
                mode_next = MODE_TEMPO_NUM;
                num_next  = '0;
            end
            else if (ch == CH_P)
            begin
                mode_next = MODE_PAUSE_NUM;
                num_next  = '0;
            end
            else if (ch >= CH_A && ch <= CH_G)
            begin
                slot_next = 5'((ch - CH_A) * 8'd3);
                mode_next = MODE_NOTE_ACC;
                num_next  = '0;
            end
        end
    end

    assign sts.ev       = ev;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign rem_sh       = {rem_reg, quo_reg[DUR_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            oct_reg       <= OCT_RST;
            tempo_reg     <= T_RST;
            dlen_reg      <= L_RST;
            num_reg       <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                mode_reg  <= mode_next;
                oct_reg   <= oct_next;
                tempo_reg <= tempo_next;
                dlen_reg  <= dlen_next;
                num_reg   <= num_next;
                slot_reg  <= slot_next;
            end
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && ev)
        begin
            job_pause_reg <= ev_pause;
            job_dot_reg   <= ev_dot;
            job_freq_reg  <= ev_pause ? '0 : ev_freq;
            job_tempo_reg <= tempo_reg;
            job_len_reg   <= ev_len;
        end
        if (cmd.mul)
        begin
            prod_reg    <= PW'(job_tempo_reg) * PW'(job_len_reg);
            job_sat_reg <= (job_tempo_reg == '0) || (job_len_reg == '0);
            rem_reg     <= '0;
            quo_reg     <= job_dot_reg ? DUR_DOT : DUR_PLAIN;
        end
        if (cmd.div)
        begin
            // restoring step: shift in the next dividend bit, subtract when it fits
            if (rem_sh >= {1'b0, prod_reg})
            begin
                rem_reg <= PW'(rem_sh - {1'b0, prod_reg});
                quo_reg <= {quo_reg[DUR_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[PW-1:0];
                quo_reg <= {quo_reg[DUR_W-2:0], 1'b0};
            end
        end
        if (cmd.dur)
            dur_reg <= job_sat_reg ? DUR_SAT : quo_reg;
        if (cmd.x85)
            x85_reg <= X85_W'(dur_reg) * X85_W'(PCT85);
        if (cmd.scale)
            scale_reg <= SCALE_W'(x85_reg) * SCALE_W'(RECIP100);
        if (cmd.load)
        begin
            o_pause_reg <= job_pause_reg;
            o_freq_reg  <= job_freq_reg;
            o_dur_reg   <= dur_reg;
            o_snd_reg   <= scale_reg[RECIP_SH +: DUR_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {4'b0, o_snd_reg, o_dur_reg, o_freq_reg, o_pause_reg};

endmodule

>>> hw/rtl/tune_string_note_parser_unit.sv
// Top level of the tune string note parser: stream ports, sequencer and datapath.
// Depends on tsnp_pkg, tsnp_ctrl and tsnp_dp.
//
// Usage:
//   s_axis carries one tune character per word (ASCII, 0 ends the tune and
//   restores octave 4, tempo 120, length 4). m_axis carries one event per
//   note or pause that a character completes.
//   A character that completes no event is taken in the idle state and input
//   stays ready. A character that completes an event is parsed, then
//   tempo * length is formed, 19 restoring divide steps run, three steps
//   settle the duration and scale it by 85/100, and the result is loaded
//   into the output register; input is held off while this sequence runs.
//   The result waits in an output register; input is accepted again as soon
//   as it is loaded, so a stalled receiver only holds the block when a
//   second event is ready before the first one is taken.
//   Reset (rst_n low, asynchronous) clears parser state to its defaults and
//   drops any pending output word.
module tune_string_note_parser_unit
    import tsnp_pkg::*;
#(
    parameter int NUMBER_MAX = 999
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [0] is_pause, [13:1] freq_hz,
                                        // [32:14] duration_ms, [51:33] sound_ms
);

    cmd_t cmd;
    sts_t sts;

    tsnp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    tsnp_dp #(
        .NUMBER_MAX (NUMBER_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

>>> verif/tb.sv
// Testbench for tune_string_note_parser_unit: drives random and directed tune
// characters, predicts each note/pause event and checks the output words.
// Depends on tsnp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb;
    import tsnp_pkg::*;

    localparam int NUM_MAX     = 999;
    localparam int WATCH_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 40;
    localparam logic [18:0] DUR_FULL = 19'd360000;

    // one note or pause event as it appears on m_axis_tdata (last member lowest)
    typedef struct packed {
        logic [18:0] sound_ms;
        logic [18:0] duration_ms;
        logic [12:0] freq_hz;
        logic        is_pause;
    } note_event_t;

    // base pitch per slot: three slots per letter (plain, flat, sharp)
    localparam int PITCH [21] = '{
        440, 415, 466, 494, 466, 523, 262, 247, 277, 294, 277,
        311, 330, 311, 349, 349, 330, 370, 392, 370, 415
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] ch
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;           // [0] is_pause, [13:1] freq_hz,
                                         // [32:14] duration_ms, [51:33] sound_ms

    logic [7:0]  char_queue [$];         // characters waiting for the driver
    note_event_t event_queue [$];        // predicted events not yet seen
    int          mismatches = 0;
    int          words_in = 0;
    logic        took = 1'b0;

    // parser shadow state
    mode_t       mode = MODE_IDLE;
    logic [2:0]  octave = 3'd4;
    logic [9:0]  tempo = 10'd120;
    logic [9:0]  dflt_len = 10'd4;
    logic [9:0]  num_val = 10'd0;
    logic [4:0]  slot = 5'd0;

    tune_string_note_parser_unit #(.NUMBER_MAX(NUM_MAX)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Event prediction
    // ------------------------------------------------------------------
    function automatic note_event_t make_event(input logic pause, input logic dotted);
        note_event_t ev;
        longint      len;
        longint      dur;
        int          pitch;
        len = (num_val != 0) ? num_val : dflt_len;
        if (tempo == 0 || len == 0)
            dur = DUR_FULL;
        else
            dur = (dotted ? 360000 : 240000) / (longint'(tempo) * len);
        ev.is_pause    = pause;
        ev.freq_hz     = '0;
        if (!pause) begin
            pitch = PITCH[(slot < 21) ? slot : 0];
            if (octave < 4)
                ev.freq_hz = 13'(pitch >> (4 - octave));
            else
                ev.freq_hz = 13'(pitch << (octave - 4));
        end
        ev.duration_ms = 19'(dur);
        ev.sound_ms    = 19'((dur * 85) / 100);
        return ev;
    endfunction

    function automatic logic is_num_char(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    // add a digit, saturate at the number ceiling
    task automatic add_digit(input logic [7:0] c);
        int v;
        v = num_val * 10 + (c - CH_0);
        num_val = (v > NUM_MAX) ? 10'(NUM_MAX) : 10'(v);
    endtask

    task automatic restore_defaults();
        mode     = MODE_IDLE;
        octave   = 3'd4;
        tempo    = 10'd120;
        dflt_len = 10'd4;
        num_val  = '0;
        slot     = '0;
    endtask

    // advance the shadow parser by one character, queue any event it completes
    task automatic parse_char(input logic [7:0] c);
        case (mode)
            MODE_OCT_WAIT:
            begin
                mode = MODE_IDLE;
                if (c >= CH_1 && c <= CH_7)
                begin
                    octave = 3'(c - CH_0);
                    return;
                end
            end
            MODE_LEN_NUM, MODE_TEMPO_NUM:
            begin
                if (is_num_char(c))
                begin
                    add_digit(c);
                    return;
                end
                if (mode == MODE_TEMPO_NUM)
                    tempo = num_val;
                else if (num_val != 0)
                    dflt_len = num_val;
                mode = MODE_IDLE;
            end
            MODE_NOTE_ACC, MODE_NOTE_NUM, MODE_PAUSE_NUM:
            begin
                if (mode == MODE_NOTE_ACC)
                begin
                    mode = MODE_NOTE_NUM;
                    if (c == CH_MINUS || c == CH_PLUS)
                    begin
                        slot = slot + ((c == CH_MINUS) ? 5'd1 : 5'd2);
                        return;
                    end
                end
                if (is_num_char(c))
                begin
                    add_digit(c);
                    return;
                end
                // a dot closes the event as dotted; anything else closes it plain
                event_queue.push_back(make_event(mode == MODE_PAUSE_NUM, c == CH_DOT));
                mode = MODE_IDLE;
                if (c == CH_DOT)
                    return;
            end
            default:
                mode = MODE_IDLE;
        endcase

        if (c == CH_NUL)
            restore_defaults();
        else if (c == CH_LT)
        begin
            if (octave > OCT_MIN)
                octave = octave - 3'd1;
        end
        else if (c == CH_GT)
        begin
            if (octave < OCT_MAX)
                octave = octave + 3'd1;
        end
        else if (c == CH_O)
            mode = MODE_OCT_WAIT;
        else if (c == CH_L || c == CH_T || c == CH_P)
        begin
            mode    = (c == CH_L) ? MODE_LEN_NUM : (c == CH_T) ? MODE_TEMPO_NUM : MODE_PAUSE_NUM;
            num_val = '0;
        end
        else if (c >= CH_A && c <= CH_G)
        begin
            slot    = 5'((c - CH_A) * 3);
            mode    = MODE_NOTE_ACC;
            num_val = '0;
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Input side: predict on every accepted word, check every output word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        note_event_t got;
        note_event_t want;
        if (rst_n)
        begin
            took <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_char(s_axis_tdata);
                words_in++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[51:0];
                if (event_queue.size() == 0)
                    report("unexpected event, is_pause", got.is_pause, 0);
                else
                begin
                    want = event_queue.pop_front();
                    if (got.is_pause != want.is_pause)
                        report("is_pause", got.is_pause, want.is_pause);
                    if (got.freq_hz != want.freq_hz)
                        report("freq_hz", got.freq_hz, want.freq_hz);
                    if (got.duration_ms != want.duration_ms)
                        report("duration_ms", got.duration_ms, want.duration_ms);
                    if (got.sound_ms != want.sound_ms)
                        report("sound_ms", got.sound_ms, want.sound_ms);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: present the next character once the previous word is taken
    // ------------------------------------------------------------------
    int src_gap = 0;
    int src_calm = 0;

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || took))
        begin
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (char_queue.size() > 0)
            begin
                s_axis_tdata  <= char_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                // mostly back to back, some short gaps, a few long ones
                if (src_calm > 0)
                begin
                    src_calm <= src_calm - 1;
                    src_gap  <= 0;
                end
                else if ($urandom_range(0, 99) < 2)
                    src_calm <= $urandom_range(50, 150);
                else if ($urandom_range(0, 99) < 4)
                    src_gap <= $urandom_range(20, 60);
                else if ($urandom_range(0, 99) < 35)
                    src_gap <= $urandom_range(1, 4);
                else
                    src_gap <= 0;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold to back the block up
    // ------------------------------------------------------------------
    int   snk_stall = 0;
    int   snk_calm = 0;
    logic hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!hold_done && words_in >= 150)
        begin
            hold_done     <= 1'b1;
            snk_stall     <= 600;
            m_axis_tready <= 1'b0;
        end
        else if (snk_stall > 0)
        begin
            snk_stall     <= snk_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (snk_calm > 0)
        begin
            snk_calm      <= snk_calm - 1;
            m_axis_tready <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 2)
        begin
            snk_calm      <= $urandom_range(100, 300);
            m_axis_tready <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            snk_stall     <= $urandom_range(20, 80);
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            snk_stall     <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_text(input string s);
        foreach (s[i])
            char_queue.push_back(8'(s[i]));
    endtask

    task automatic push_number(input int v);
        push_text($sformatf("%0d", v));
    endtask

    // a length or tempo value: mostly ordinary, sometimes absent, zero or huge
    task automatic push_length_value();
        case ($urandom_range(0, 9))
            0: ;
            1: push_number(0);
            2: push_number($urandom_range(1000, 99999));   // saturates
            3: push_number($urandom_range(100, 999));
            default: push_number($urandom_range(1, 32));
        endcase
    endtask

    task automatic push_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            char_queue.push_back(CH_A + 8'($urandom_range(0, 6)));
            case ($urandom_range(0, 2))
                0: char_queue.push_back(CH_MINUS);
                1: char_queue.push_back(CH_PLUS);
                default: ;
            endcase
            push_length_value();
            if ($urandom_range(0, 3) == 0)
                char_queue.push_back(CH_DOT);
        end
        else if (pick < 55)
        begin
            char_queue.push_back(CH_P);
            push_length_value();
            if ($urandom_range(0, 3) == 0)
                char_queue.push_back(CH_DOT);
        end
        else if (pick < 62)
        begin
            char_queue.push_back(CH_L);
            push_length_value();
        end
        else if (pick < 68)
        begin
            char_queue.push_back(CH_T);
            if ($urandom_range(0, 7) == 0)
                push_length_value();
            else
                push_number($urandom_range(30, 300));
        end
        else if (pick < 76)
        begin
            char_queue.push_back(CH_O);
            char_queue.push_back(8'($urandom_range(0, 255) < 200 ?
                                   $urandom_range(CH_0, CH_9) : $urandom_range(0, 255)));
        end
        else if (pick < 86)
            char_queue.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
        else if (pick < 88)
            char_queue.push_back(CH_NUL);
        else
            char_queue.push_back(8'($urandom_range(1, 255)));   // noise
    endtask

    task automatic wait_drained();
        wait (char_queue.size() == 0 && !s_axis_tvalid && event_queue.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        restore_defaults();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes of tempo and length, octave limits, accidentals,
        // saturating numbers, length zero, tempo zero, bad octave, end of tune
        push_text("T1L1P.O7>C+2A<<<<<<<<G-L0E9999.T0B");
        char_queue.push_back(8'hFF);
        char_queue.push_back(CH_NUL);
        push_text("T999L999DO9FL");
        char_queue.push_back(CH_NUL);
        wait_drained();

        // random part in two halves; the sender pauses in between until
        // every predicted event has come out
        repeat (2)
        begin
            while (char_queue.size() < 450)
                push_token();
            char_queue.push_back(CH_NUL);
            wait_drained();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
